// ===== src/tspq_pkg.sv =====
package tspq_pkg;

   localparam int PTS_W    = 64;
   localparam int SIZE_W   = 24;
   localparam int TAG_W    = 32;
   localparam int SERIAL_W = 32;
   localparam int BYTES_W  = 31;
   localparam int OVH_W    = 8;
   localparam int ACT_W    = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // action codes
   localparam logic [ACT_W-1:0] ACT_PUT   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_GET   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_START = 3'd3;
   localparam logic [ACT_W-1:0] ACT_ABORT = 3'd4;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABORTED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   // register indexes
   localparam logic REG_ENTRY_OVERHEAD = 1'b0;
   localparam logic [OVH_W-1:0] OVERHEAD_RESET = 8'd128;

   typedef struct packed {
      logic signed [PTS_W-1:0] pts;
      logic [SIZE_W-1:0]       size;
      logic [TAG_W-1:0]        tag;
      logic [SERIAL_W-1:0]     serial;
      logic                    flush;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic insert;    // place the new entry this cycle
      logic pop;       // every cell takes its right neighbor
      logic tail_hit;  // tail timestamp <= new one, append at the tail
   } cell_ctl_type;

   function automatic logic pts_le(input logic signed [PTS_W-1:0] a,
                                   input logic signed [PTS_W-1:0] b);
      pts_le = (a <= b);
   endfunction

endpackage

// ===== src/tspq_channels.sv =====
interface tspq_req_if;
   logic                              valid;
   logic                              ready;
   logic [tspq_pkg::ACT_W-1:0]        action;
   logic signed [tspq_pkg::PTS_W-1:0] pts;
   logic [tspq_pkg::SIZE_W-1:0]       payload_size;
   logic [tspq_pkg::TAG_W-1:0]        payload_tag;
   logic                              is_flush;

   modport source (output valid, action, pts, payload_size, payload_tag, is_flush,
                   input ready);
   modport sink (input valid, action, pts, payload_size, payload_tag, is_flush,
                 output ready);
endinterface

interface tspq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tspq_pkg::STATUS_W-1:0]     status;
   logic signed [tspq_pkg::PTS_W-1:0] out_pts;
   logic [tspq_pkg::SIZE_W-1:0]       out_size;
   logic [tspq_pkg::TAG_W-1:0]        out_tag;
   logic [tspq_pkg::SERIAL_W-1:0]     out_serial;
   logic                              out_is_flush;
   logic [tspq_pkg::COUNT_W-1:0]      entry_count;
   logic [tspq_pkg::BYTES_W-1:0]      byte_total;

   modport source (output valid, status, out_pts, out_size, out_tag, out_serial,
                   out_is_flush, entry_count, byte_total, input ready);
   modport sink (input valid, status, out_pts, out_size, out_tag, out_serial,
                 out_is_flush, entry_count, byte_total, output ready);
endinterface

// ===== src/tspq_cell.sv =====
module tspq_cell #(
   parameter int INDEX   = 0,
   parameter int CNT_W   = 7
) (
   input  logic                  clock,
   input  tspq_pkg::cell_ctl_type ctl,
   input  logic [CNT_W-1:0]      count,
   input  tspq_pkg::entry_type   new_entry,
   input  tspq_pkg::entry_type   prev_entry,
   input  tspq_pkg::entry_type   next_entry,
   input  logic                  prev_shift,
   output logic                  shift,
   output logic                  tail_le,
   output tspq_pkg::entry_type   entry
);
   import tspq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      occupied;
   logic      at_count;
   logic      is_tail;
   logic      ge;

   assign occupied = CNT_W'(INDEX) < count;
   assign at_count = CNT_W'(INDEX) == count;
   assign is_tail  = CNT_W'(INDEX + 1) == count;

   // new entry sorts at or before this one
   assign ge      = occupied & pts_le(new_entry.pts, entry_ff.pts);
   assign tail_le = is_tail & pts_le(entry_ff.pts, new_entry.pts);
   assign shift   = ge & ~ctl.tail_hit;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (prev_shift) begin
            entry_in = prev_entry;
         end else if (shift | at_count) begin
            entry_in = new_entry;
         end
      end else if (ctl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/timestamp_sorted_packet_queue_core.sv =====
// a request is held in the request holding stage until the response slot is free or being
//   drained; its response is then registered as the request runs
// a new request is refused while one is held; each request runs in one pass of the cell chain
// a request may be taken while the previous response still waits on rsp_bus.ready
// reset (synchronous, active high): queue empty, byte total and serial zero,
//   queue aborted, entry overhead 128; entry storage is not cleared
module timestamp_sorted_packet_queue_core #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   tspq_req_if.sink    req_bus,
   tspq_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tspq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // ---------------------------------------------------------------
   // configuration: one register, entry overhead at byte address 0
   // ---------------------------------------------------------------
   logic [OVH_W-1:0] overhead_ff, overhead_in;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      overhead_in = overhead_ff;
      if (csr_write && csr_paddr[2] == REG_ENTRY_OVERHEAD) begin
         overhead_in = csr_pwdata[OVH_W-1:0];
      end
   end

   // reads beyond the register list return zero
   assign csr_prdata = (csr_paddr[2] == REG_ENTRY_OVERHEAD) ? {24'd0, overhead_ff} : 32'd0;

   // ---------------------------------------------------------------
   // request holding stage
   // ---------------------------------------------------------------
   logic                    pending_ff, pending_in;
   logic [ACT_W-1:0]        action_ff;
   logic signed [PTS_W-1:0] pts_ff;
   logic [SIZE_W-1:0]       size_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic                    flush_ff;
   logic                    req_take;
   logic                    exec;

   logic                    rsp_valid_ff, rsp_valid_in;

   assign req_bus.ready = ~pending_ff;
   assign req_take      = req_bus.valid & req_bus.ready;
   // run the request once the response register is free or being drained
   assign exec          = pending_ff & (~rsp_valid_ff | rsp_bus.ready);

   always_comb begin
      pending_in = pending_ff;
      if (req_take) begin
         pending_in = 1'b1;
      end else if (exec) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff <= req_bus.action;
         pts_ff    <= req_bus.pts;
         size_ff   <= req_bus.payload_size;
         tag_ff    <= req_bus.payload_tag;
         flush_ff  <= req_bus.is_flush;
      end
   end

   // ---------------------------------------------------------------
   // queue state and action decode
   // ---------------------------------------------------------------
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [SERIAL_W-1:0] serial_ff, serial_in;
   logic                aborted_ff, aborted_in;

   logic                full;
   logic                empty;
   logic                is_start;
   logic                ins_go;
   logic                pop_go;
   logic                emit;
   logic [STATUS_W-1:0] status;
   entry_type           new_entry;
   entry_type           head;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign is_start = action_ff == ACT_START;

   // start puts a flush marker with size and tag zero
   always_comb begin
      new_entry.pts    = pts_ff;
      new_entry.size   = is_start ? '0 : size_ff;
      new_entry.tag    = is_start ? '0 : tag_ff;
      new_entry.flush  = is_start | flush_ff;
      new_entry.serial = serial_ff + SERIAL_W'(new_entry.flush);
   end

   always_comb begin
      status     = ST_OK;
      ins_go     = 1'b0;
      pop_go     = 1'b0;
      emit       = 1'b0;
      count_in   = count_ff;
      bytes_in   = bytes_ff;
      serial_in  = serial_ff;
      aborted_in = aborted_ff;
      if (exec) begin
         case (action_ff)
            ACT_PUT, ACT_START: begin
               // start clears the abort before its marker is placed
               if (action_ff == ACT_PUT && aborted_ff) begin
                  status = ST_ABORTED;
               end else if (full) begin
                  status = ST_FULL;
               end else begin
                  ins_go = 1'b1;
               end
               if (is_start) begin
                  aborted_in = 1'b0;
               end
               if (ins_go) begin
                  serial_in = new_entry.serial;
                  count_in  = count_ff + 1'b1;
                  bytes_in  = bytes_ff + BYTES_W'(new_entry.size) + BYTES_W'(overhead_ff);
               end
            end
            ACT_GET: begin
               if (aborted_ff) begin
                  status = ST_ABORTED;
               end else if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  pop_go   = 1'b1;
                  emit     = 1'b1;
                  count_in = count_ff - 1'b1;
                  // overhead in force now, not the one at insertion
                  bytes_in = bytes_ff - BYTES_W'(head.size) - BYTES_W'(overhead_ff);
               end
            end
            ACT_PEEK: begin
               // peek ignores the abort
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  emit = 1'b1;
               end
            end
            ACT_ABORT: begin
               aborted_in = 1'b1;
            end
            ACT_CLEAR: begin
               // abort flag and serial survive a clear
               count_in = '0;
               bytes_in = '0;
            end
            default: begin
               // unused codes do nothing
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // cell chain: cell 0 is the head; insert shifts the cells at and
   // after the insertion point one place right, get shifts all left
   // ---------------------------------------------------------------
   cell_ctl_type           ctl;
   entry_type              cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_shift;
   logic [QUEUE_DEPTH-1:0] cell_tail_le;

   always_comb begin
      ctl.insert   = ins_go;
      ctl.pop      = pop_go;
      // new timestamp not below the tail: append, no shifting
      ctl.tail_hit = |cell_tail_le;
   end

   assign head = cell_entry[0];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      logic      prev_s;

      if (i == 0) begin : g_first
         assign prev_e = new_entry;
         assign prev_s = 1'b0;
      end else begin : g_mid
         assign prev_e = cell_entry[i-1];
         assign prev_s = cell_shift[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         // past the last held entry, contents do not matter
         assign next_e = cell_entry[i];
      end else begin : g_inner
         assign next_e = cell_entry[i+1];
      end

      tspq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .new_entry  (new_entry),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .prev_shift (prev_s),
         .shift      (cell_shift[i]),
         .tail_le    (cell_tail_le[i]),
         .entry      (cell_entry[i])
      );
   end

   // ---------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic signed [PTS_W-1:0] rsp_pts_ff;
   logic [SIZE_W-1:0]       rsp_size_ff;
   logic [TAG_W-1:0]        rsp_tag_ff;
   logic [SERIAL_W-1:0]     rsp_serial_ff;
   logic                    rsp_flush_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic [BYTES_W-1:0]      rsp_bytes_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_status_ff <= status;
         // entry fields read zero unless a get or peek returns the head
         rsp_pts_ff    <= emit ? head.pts    : '0;
         rsp_size_ff   <= emit ? head.size   : '0;
         rsp_tag_ff    <= emit ? head.tag    : '0;
         rsp_serial_ff <= emit ? head.serial : '0;
         rsp_flush_ff  <= emit & head.flush;
         rsp_count_ff  <= COUNT_W'(count_in);
         rsp_bytes_ff  <= bytes_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.out_pts      = rsp_pts_ff;
   assign rsp_bus.out_size     = rsp_size_ff;
   assign rsp_bus.out_tag      = rsp_tag_ff;
   assign rsp_bus.out_serial   = rsp_serial_ff;
   assign rsp_bus.out_is_flush = rsp_flush_ff;
   assign rsp_bus.entry_count  = rsp_count_ff;
   assign rsp_bus.byte_total   = rsp_bytes_ff;

   // ---------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         bytes_ff     <= '0;
         serial_ff    <= '0;
         aborted_ff   <= 1'b1;
         overhead_ff  <= OVERHEAD_RESET;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         serial_ff    <= serial_in;
         aborted_ff   <= aborted_in;
         overhead_ff  <= overhead_in;
      end
   end

endmodule

// ===== src/tspq_checker.sv =====
module tspq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tspq_pkg::STATUS_W-1:0]     status,
   input logic signed [tspq_pkg::PTS_W-1:0] out_pts,
   input logic [tspq_pkg::SERIAL_W-1:0]     out_serial,
   input logic [tspq_pkg::COUNT_W-1:0]      entry_count
);
   import tspq_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_pts)
         && $stable(out_serial) && $stable(entry_count))
      else $error("stalled response changed");

   // one request in flight: no transfer in the cycle right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while one is pending");

   // an empty status means nothing is held
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_EMPTY |-> entry_count == '0)
      else $error("empty status with entries held");

   // refused or empty responses carry no entry
   a_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_EMPTY || status == ST_FULL || status == ST_ABORTED)
         |-> out_pts == '0 && out_serial == '0)
      else $error("entry fields set without a returned entry");

endmodule

bind timestamp_sorted_packet_queue_core tspq_checker u_tspq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .status      (rsp_bus.status),
   .out_pts     (rsp_bus.out_pts),
   .out_serial  (rsp_bus.out_serial),
   .entry_count (rsp_bus.entry_count)
);
